// ----- src/watchdog_command_line_parser_defines.svh -----
// Assertion macros for the watchdog command line parser checker.
// Used by wclp_checker.sv; expects clk and arst_n in scope.
`ifndef WATCHDOG_COMMAND_LINE_PARSER_DEFINES_SVH
`define WATCHDOG_COMMAND_LINE_PARSER_DEFINES_SVH

// same-cycle implication
`define WCLP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WCLP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/wclp_pkg.sv -----
// Shared types, codes and tables for the watchdog command line parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package wclp_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
	localparam logic [7:0] CHAR_COMMA   = 8'h2C;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_LOW_A   = 8'h61;
	localparam logic [7:0] CHAR_LOW_Z   = 8'h7A;
	localparam logic [7:0] CHAR_C       = 8'h43;
	localparam logic [7:0] CHAR_N       = 8'h4E;
	localparam logic [7:0] CHAR_R       = 8'h52;
	localparam logic [7:0] CASE_OFFSET  = 8'd32;

	localparam logic [2:0] ST_BUSY        = 3'd0;
	localparam logic [2:0] ST_OK          = 3'd1;
	localparam logic [2:0] ST_NO_EQUALS   = 3'd2;
	localparam logic [2:0] ST_BAD_CMD     = 3'd3;
	localparam logic [2:0] ST_BAD_FORMAT  = 3'd4;
	localparam logic [2:0] ST_BAD_TIMEOUT = 3'd5;

	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_DISABLE = 2'd1;
	localparam logic [1:0] ACT_ENABLE  = 2'd2;
	localparam logic [1:0] ACT_NOACT   = 2'd3;

	localparam logic [1:0] CMD_DISABLE = 2'd0;
	localparam logic [1:0] CMD_ENABLE  = 2'd1;
	localparam logic [1:0] CMD_NOACT   = 2'd2;

	localparam logic [2:0] CODE_MAX = 3'd7;

	typedef enum logic [3:0] {
		CLS_OTHER,
		CLS_SPACE,
		CLS_EQUALS,
		CLS_COMMA,
		CLS_NEWLINE,
		CLS_DIGIT,
		CLS_CMD_C,
		CLS_CMD_N,
		CLS_CMD_R,
		CLS_RESTART
	} char_class_t;

	typedef struct packed {
		char_class_t cls;
		logic [3:0]  digit;
	} beat_t;

	typedef enum logic [6:0] {
		PH_WAIT_EQ    = 7'b0000001,
		PH_GET_CMD    = 7'b0000010,
		PH_WAIT_COMMA = 7'b0000100,
		PH_WAIT_TMO   = 7'b0001000,
		PH_GET_TMO    = 7'b0010000,
		PH_WAIT_EOL   = 7'b0100000,
		PH_SKIP_EOL   = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic        line_done;
		logic [2:0]  status;
		logic [1:0]  action;
		logic [2:0]  period_code;
		logic [10:0] granted_ms;
	} result_t;

	function automatic logic [10:0] step_ms(input logic [2:0] code);
		logic [10:0] ms;
		unique case (code)
			3'd0: ms = 11'd15;
			3'd1: ms = 11'd30;
			3'd2: ms = 11'd60;
			3'd3: ms = 11'd120;
			3'd4: ms = 11'd250;
			3'd5: ms = 11'd500;
			3'd6: ms = 11'd1000;
			default: ms = 11'd2000;
		endcase
		return ms;
	endfunction

endpackage

`default_nettype wire

// ----- src/wclp_front.sv -----
// Front end: folds case and classifies each received character.
// Depends on wclp_pkg.
`default_nettype none

module wclp_front (
	input  logic          [7:0] char_in,
	input  logic                restart,
	output wclp_pkg::beat_t     beat
);
	import wclp_pkg::*;

	logic [7:0] up;

	always_comb begin
		up = char_in;
		if (char_in >= CHAR_LOW_A && char_in <= CHAR_LOW_Z) begin
			up = char_in - CASE_OFFSET;
		end
		beat.digit = up[3:0];
		if (restart) begin
			beat.cls = CLS_RESTART;
		end else if (up == CHAR_SPACE) begin
			beat.cls = CLS_SPACE;
		end else if (up == CHAR_EQUALS) begin
			beat.cls = CLS_EQUALS;
		end else if (up == CHAR_COMMA) begin
			beat.cls = CLS_COMMA;
		end else if (up == CHAR_NEWLINE) begin
			beat.cls = CLS_NEWLINE;
		end else if (up >= CHAR_ZERO && up <= CHAR_NINE) begin
			beat.cls = CLS_DIGIT;
		end else if (up == CHAR_C) begin
			beat.cls = CLS_CMD_C;
		end else if (up == CHAR_N) begin
			beat.cls = CLS_CMD_N;
		end else if (up == CHAR_R) begin
			beat.cls = CLS_CMD_R;
		end else begin
			beat.cls = CLS_OTHER;
		end
	end

endmodule

`default_nettype wire

// ----- src/wclp_queue.sv -----
// Short queue of classified beats between front end and parser.
// Depends on wclp_pkg.
`default_nettype none

module wclp_queue #(
	parameter int DEPTH = wclp_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wclp_pkg::beat_t beat_in,
	output logic            full,
	input  logic            pop,
	output wclp_pkg::beat_t beat_out,
	output logic            empty
);
	import wclp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	beat_t            slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign beat_out = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= beat_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/wclp_back.sv -----
// Back end: command line state machine, timeout accumulator, result register.
// Depends on wclp_pkg.
`default_nettype none

module wclp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              beat_valid,
	input  wclp_pkg::beat_t   beat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output wclp_pkg::result_t result
);
	import wclp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  cmd_q, cmd_d;
	logic [15:0] acc_q, acc_d;
	logic [15:0] acc_x10;
	logic        out_valid_q;
	result_t     res_q, res_d, fin, err;
	logic [2:0]  code;
	logic        advance;

	assign advance   = beat_valid && (!out_valid_q || !out_stall);
	assign pop       = advance;
	assign out_valid = out_valid_q;
	assign result    = res_q;

	assign acc_x10 = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0};

	// step search for the enable command
	always_comb begin
		code = CODE_MAX;
		for (int i = 6; i >= 0; i--) begin
			if (acc_q <= {5'b0, step_ms(3'(i))}) begin
				code = 3'(i);
			end
		end
	end

	always_comb begin
		fin           = '0;
		fin.line_done = 1'b1;
		fin.status    = ST_OK;
		if (cmd_q == CMD_DISABLE) begin
			fin.action = ACT_DISABLE;
		end else if (cmd_q == CMD_ENABLE) begin
			fin.action      = ACT_ENABLE;
			fin.period_code = code;
			fin.granted_ms  = step_ms(code);
		end else begin
			fin.action = ACT_NOACT;
		end
	end

	always_comb begin
		phase_d       = phase_q;
		cmd_d         = cmd_q;
		acc_d         = acc_q;
		res_d         = '0;
		err           = '0;
		err.line_done = 1'b1;
		if (beat.cls == CLS_RESTART) begin
			phase_d = PH_WAIT_EQ;
			cmd_d   = CMD_DISABLE;
			acc_d   = '0;
		end else begin
			unique case (phase_q)
				PH_WAIT_EQ: begin
					if (beat.cls == CLS_EQUALS) begin
						phase_d = PH_GET_CMD;
					end else if (beat.cls != CLS_SPACE) begin
						err.status = ST_NO_EQUALS;
						res_d      = err;
					end
				end
				PH_GET_CMD: begin
					if (beat.cls == CLS_CMD_C) begin
						cmd_d   = CMD_NOACT;
						phase_d = PH_SKIP_EOL;
					end else if (beat.cls == CLS_CMD_N) begin
						cmd_d   = CMD_DISABLE;
						phase_d = PH_SKIP_EOL;
					end else if (beat.cls == CLS_CMD_R) begin
						cmd_d   = CMD_ENABLE;
						phase_d = PH_WAIT_COMMA;
					end else if (beat.cls != CLS_SPACE) begin
						err.status = ST_BAD_CMD;
						res_d      = err;
					end
				end
				PH_WAIT_COMMA: begin
					if (beat.cls == CLS_COMMA) begin
						phase_d = PH_WAIT_TMO;
						acc_d   = '0;
					end else if (beat.cls != CLS_SPACE) begin
						err.status = ST_BAD_FORMAT;
						res_d      = err;
					end
				end
				PH_WAIT_TMO: begin
					if (beat.cls == CLS_DIGIT) begin
						acc_d   = {12'b0, beat.digit};
						phase_d = PH_GET_TMO;
					end else if (beat.cls != CLS_SPACE) begin
						err.status = ST_BAD_TIMEOUT;
						res_d      = err;
					end
				end
				PH_GET_TMO: begin
					if (beat.cls == CLS_SPACE) begin
						phase_d = PH_WAIT_EOL;
					end else if (beat.cls == CLS_DIGIT) begin
						acc_d = acc_x10 + {12'b0, beat.digit};
					end else if (beat.cls == CLS_NEWLINE) begin
						res_d = fin;
					end else begin
						err.status = ST_BAD_TIMEOUT;
						res_d      = err;
					end
				end
				PH_WAIT_EOL: begin
					if (beat.cls == CLS_NEWLINE) begin
						res_d = fin;
					end else if (beat.cls != CLS_SPACE) begin
						err.status = ST_BAD_FORMAT;
						res_d      = err;
					end
				end
				PH_SKIP_EOL: begin
					if (beat.cls == CLS_NEWLINE) begin
						res_d = fin;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT_EQ;
			cmd_q       <= CMD_DISABLE;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q     <= phase_d;
				cmd_q       <= cmd_d;
				acc_q       <= acc_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/watchdog_command_line_parser.sv -----
// Watchdog command line parser: "= cmd [, timeout]" lines, one character a beat.
// Top level; depends on wclp_pkg, wclp_front, wclp_queue and wclp_back.
//
// Input channel in_valid/in_stall carries char_in and restart; restart set
// re-initializes the parser and ignores char_in. Output channel
// out_valid/out_stall gives exactly one result per input beat: line_done,
// status, action, period_code and granted_timeout_ms.
// An accepted beat is written into the queue; when the output register
// is free, the parser pops it and registers its result with out_valid.
// Throughput is one beat per cycle while out_stall is low, set by the
// parser step (state update and multiply by ten of the timeout accumulator).
// A queue of QUEUE_DEPTH beats sits between the classifier and the parser;
// in_stall rises only when it is full. While out_valid and out_stall are
// both high the result register holds, the parser stops and the queue fills.
// Reset empties the queue, clears the output valid, and puts the parser in
// the wait-for-equals phase with the disable command and a zero timeout.
`default_nettype none

module watchdog_command_line_parser #(
	parameter int QUEUE_DEPTH = wclp_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        line_done,
	output logic [2:0]  status,
	output logic [1:0]  action,
	output logic [2:0]  period_code,
	output logic [10:0] granted_timeout_ms
);
	import wclp_pkg::*;

	beat_t   beat_in;
	beat_t   beat_out;
	logic    q_full;
	logic    q_empty;
	logic    q_pop;
	result_t res;

	wclp_front u_front (
		.char_in (char_in),
		.restart (restart),
		.beat    (beat_in)
	);

	wclp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid && !q_full),
		.beat_in  (beat_in),
		.full     (q_full),
		.pop      (q_pop),
		.beat_out (beat_out),
		.empty    (q_empty)
	);

	wclp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (!q_empty),
		.beat       (beat_out),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (res)
	);

	assign in_stall           = q_full;
	assign line_done          = res.line_done;
	assign status             = res.status;
	assign action             = res.action;
	assign period_code        = res.period_code;
	assign granted_timeout_ms = res.granted_ms;

endmodule

`default_nettype wire

// ----- src/wclp_checker.sv -----
// Port-level checker for the watchdog command line parser, with its bind.
// Depends on wclp_pkg and watchdog_command_line_parser_defines.svh.
`default_nettype none
`include "watchdog_command_line_parser_defines.svh"

module wclp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        line_done,
	input logic [2:0]  status,
	input logic [1:0]  action,
	input logic [2:0]  period_code,
	input logic [10:0] granted_timeout_ms
);
	import wclp_pkg::*;

	`WCLP_ASSERT_NOW(a_busy_is_blank, out_valid && !line_done, status == ST_BUSY && action == ACT_NONE && period_code == 3'd0 && granted_timeout_ms == 11'd0, "busy result carries data")
	`WCLP_ASSERT_NOW(a_no_period_without_enable, out_valid && action != ACT_ENABLE, period_code == 3'd0 && granted_timeout_ms == 11'd0, "period given without enable")
	`WCLP_ASSERT_NOW(a_enable_step, out_valid && action == ACT_ENABLE, line_done && status == ST_OK && granted_timeout_ms == step_ms(period_code), "granted timeout does not match period code")
	`WCLP_ASSERT_NOW(a_error_no_action, out_valid && line_done && status != ST_OK, action == ACT_NONE, "error line reports an action")
	`WCLP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(line_done) && $stable(status) && $stable(action) && $stable(granted_timeout_ms), "stalled result changed")

endmodule

bind watchdog_command_line_parser wclp_checker u_wclp_checker (.*);

`default_nettype wire
